[rtl/scrf_pkg.sv]
`default_nettype none

package scrf_pkg;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_SEND  = 2'd2,
        FUNC_ABORT = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_BUSY    = 3'd1,
        KIND_TX      = 3'd2,
        KIND_BYTE    = 3'd3,
        KIND_OVF     = 3'd4,
        KIND_GAVE_UP = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RD   = 2'd1,
        ST_LOAD = 2'd2
    } emit_state_t;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_QUIET_GAP = 2'd0;
    localparam logic [1:0] REG_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_TRY_LIMIT = 2'd2;

    localparam logic [7:0]  QUIET_GAP_RST = 8'd50;
    localparam logic [10:0] TIMEOUT_RST   = 11'd1000;
    localparam logic [3:0]  TRY_LIMIT_RST = 4'd5;

    localparam logic [10:0] SINCE_MAX = 11'h7FF;

    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_DC1 = 8'h11;
    localparam logic [7:0] CH_DC2 = 8'h12;
    localparam logic [7:0] CH_DC3 = 8'h13;

    typedef struct packed {
        logic [7:0]  quiet_gap;
        logic [10:0] timeout;
        logic [3:0]  try_limit;
    } cfg_t;

    // event outcome handed from the event core to the emitter
    typedef struct packed {
        logic  single;
        kind_t kind;
        logic  emit;
    } evt_t;

endpackage

`default_nettype wire

[rtl/scrf_ram.sv]
`default_nettype none

module scrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/scrf_cfg.sv]
`default_nettype none

module scrf_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output scrf_pkg::cfg_t   cfg
);

    logic [7:0]  gap_reg;
    logic [10:0] tmo_reg;
    logic [3:0]  tries_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg   <= scrf_pkg::QUIET_GAP_RST;
            tmo_reg   <= scrf_pkg::TIMEOUT_RST;
            tries_reg <= scrf_pkg::TRY_LIMIT_RST;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                scrf_pkg::REG_QUIET_GAP: gap_reg   <= pwdata[7:0];
                scrf_pkg::REG_TIMEOUT:   tmo_reg   <= pwdata[10:0];
                scrf_pkg::REG_TRY_LIMIT: tries_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            scrf_pkg::REG_QUIET_GAP: prdata = {24'd0, gap_reg};
            scrf_pkg::REG_TIMEOUT:   prdata = {21'd0, tmo_reg};
            scrf_pkg::REG_TRY_LIMIT: prdata = {28'd0, tries_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.quiet_gap = gap_reg;
    assign cfg.timeout   = tmo_reg;
    assign cfg.try_limit = tries_reg;

endmodule

`default_nettype wire

[rtl/scrf_core.sv]
`default_nettype none

module scrf_core #(
    parameter int REPLY_BYTES = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [1:0]                     func,
    input  wire logic [7:0]                     rx_byte,
    input  wire scrf_pkg::cfg_t                 cfg,
    output logic                                ram_we,
    output logic      [$clog2(REPLY_BYTES)-1:0] ram_waddr,
    output scrf_pkg::evt_t                      evt,
    output logic      [$clog2(REPLY_BYTES)-1:0] emit_len
);

    localparam int PW = $clog2(REPLY_BYTES);
    localparam logic [PW-1:0] FILL_LIM = PW'(REPLY_BYTES - 1);

    logic [PW-1:0] fill_reg,   fill_next;
    logic          pend_reg,   pend_next;
    logic [3:0]    try_reg,    try_next;
    logic          qact_reg,   qact_next;
    logic [7:0]    qticks_reg, qticks_next;
    logic [10:0]   since_reg,  since_next;

    logic [PW-1:0] fill_inc;
    logic [10:0]   since_inc;
    logic          tick_qact;
    logic [7:0]    tick_qticks;
    logic          due;
    logic          is_start;

    assign fill_inc  = fill_reg + PW'(1);
    assign since_inc = (since_reg != scrf_pkg::SINCE_MAX) ? since_reg + 11'd1 : since_reg;
    assign is_start  = (rx_byte == scrf_pkg::CH_STX) || (rx_byte == scrf_pkg::CH_DC1) ||
                       (rx_byte == scrf_pkg::CH_DC2) || (rx_byte == scrf_pkg::CH_DC3);

    // silence wait as seen after this tick
    always_comb
    begin
        tick_qact   = qact_reg;
        tick_qticks = qticks_reg;
        if (qact_reg)
        begin
            if (qticks_reg >= cfg.quiet_gap)
            begin
                tick_qact = 1'b0;
            end
            else
            begin
                tick_qticks = qticks_reg + 8'd1;
            end
        end
    end

    assign due = !tick_qact && pend_reg && ((try_reg == 4'd0) || (since_inc > cfg.timeout));

    assign ram_waddr = fill_reg;

    always_comb
    begin
        fill_next   = fill_reg;
        pend_next   = pend_reg;
        try_next    = try_reg;
        qact_next   = qact_reg;
        qticks_next = qticks_reg;
        since_next  = since_reg;
        ram_we      = 1'b0;
        evt.single  = 1'b0;
        evt.kind    = scrf_pkg::KIND_NONE;
        evt.emit    = 1'b0;
        emit_len    = fill_inc;
        case (scrf_pkg::func_t'(func))
            scrf_pkg::FUNC_BYTE:
            begin
                pend_next   = 1'b0;
                qact_next   = 1'b1;
                qticks_next = 8'd0;
                if ((fill_reg != '0) || is_start)
                begin
                    ram_we = accept;
                    if (rx_byte == scrf_pkg::CH_ETX)
                    begin
                        evt.emit  = 1'b1;
                        fill_next = '0;
                    end
                    else if (fill_inc >= FILL_LIM)
                    begin
                        evt.single = 1'b1;
                        evt.kind   = scrf_pkg::KIND_OVF;
                        fill_next  = '0;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            scrf_pkg::FUNC_TICK:
            begin
                since_next  = since_inc;
                qact_next   = tick_qact;
                qticks_next = tick_qticks;
                if (due)
                begin
                    evt.single = 1'b1;
                    if (try_reg >= cfg.try_limit)
                    begin
                        evt.kind  = scrf_pkg::KIND_GAVE_UP;
                        pend_next = 1'b0;
                        fill_next = '0;
                    end
                    else
                    begin
                        evt.kind    = scrf_pkg::KIND_TX;
                        try_next    = try_reg + 4'd1;
                        since_next  = 11'd0;
                        qact_next   = 1'b1;
                        qticks_next = 8'd0;
                    end
                end
            end
            scrf_pkg::FUNC_SEND:
            begin
                if (pend_reg)
                begin
                    evt.single = 1'b1;
                    evt.kind   = scrf_pkg::KIND_BUSY;
                end
                else
                begin
                    pend_next = 1'b1;
                    try_next  = 4'd0;
                    fill_next = '0;
                end
            end
            default:
            begin
                try_next = cfg.try_limit;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            pend_reg   <= 1'b0;
            try_reg    <= 4'd0;
            qact_reg   <= 1'b0;
            qticks_reg <= 8'd0;
            since_reg  <= scrf_pkg::SINCE_MAX;
        end
        else if (accept)
        begin
            fill_reg   <= fill_next;
            pend_reg   <= pend_next;
            try_reg    <= try_next;
            qact_reg   <= qact_next;
            qticks_reg <= qticks_next;
            since_reg  <= since_next;
        end
    end

`ifndef ASSERT_OFF
    // frame restarts before it can reach the last store entry
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_LIM)
        else $error("frame fill past limit");
`endif

endmodule

`default_nettype wire

[rtl/scrf_out.sv]
`default_nettype none

module scrf_out #(
    parameter int REPLY_BYTES = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire scrf_pkg::evt_t                 evt,
    input  wire logic [$clog2(REPLY_BYTES)-1:0] emit_len,
    output logic                                rdy,
    output logic                                ram_re,
    output logic      [$clog2(REPLY_BYTES)-1:0] ram_raddr,
    input  wire logic [7:0]                     ram_rdata,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [2:0]                     kind,
    output logic      [7:0]                     data,
    output logic                                last
);

    localparam int PW = $clog2(REPLY_BYTES);

    scrf_pkg::emit_state_t st_reg, st_next;

    logic [PW-1:0]   idx_reg, idx_next;
    logic [PW-1:0]   len_reg;
    logic            ov_reg, ov_next;
    scrf_pkg::kind_t kind_reg;
    logic [7:0]      data_reg;
    logic            last_reg;

    logic slot_free;
    logic load_single;
    logic load_byte;
    logic last_byte;

    assign slot_free = !ov_reg || out_ready;
    assign last_byte = (idx_reg == len_reg - PW'(1));

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            scrf_pkg::ST_IDLE:
            begin
                if (accept && evt.emit)
                begin
                    st_next = scrf_pkg::ST_RD;
                end
            end
            scrf_pkg::ST_RD:
            begin
                st_next = scrf_pkg::ST_LOAD;
            end
            scrf_pkg::ST_LOAD:
            begin
                if (slot_free)
                begin
                    st_next = last_byte ? scrf_pkg::ST_IDLE : scrf_pkg::ST_RD;
                end
            end
            default:
            begin
                st_next = scrf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        rdy         = 1'b0;
        ram_re      = 1'b0;
        load_single = 1'b0;
        load_byte   = 1'b0;
        idx_next    = idx_reg;
        case (st_reg)
            scrf_pkg::ST_IDLE:
            begin
                rdy         = slot_free;
                load_single = accept && evt.single;
                if (accept && evt.emit)
                begin
                    idx_next = '0;
                end
            end
            scrf_pkg::ST_RD:
            begin
                ram_re = 1'b1;
            end
            scrf_pkg::ST_LOAD:
            begin
                load_byte = slot_free;
                if (slot_free && !last_byte)
                begin
                    idx_next = idx_reg + PW'(1);
                end
            end
            default: ;
        endcase
    end

    assign ram_raddr = idx_reg;

    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (load_single || load_byte)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= scrf_pkg::ST_IDLE;
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && evt.emit)
        begin
            len_reg <= emit_len;
        end
        if (load_single)
        begin
            kind_reg <= evt.kind;
            data_reg <= 8'd0;
            last_reg <= 1'b1;
        end
        else if (load_byte)
        begin
            kind_reg <= scrf_pkg::KIND_BYTE;
            data_reg <= ram_rdata;
            last_reg <= last_byte;
        end
    end

    assign out_valid = ov_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != scrf_pkg::ST_IDLE) |-> !rdy)
        else $error("input taken during frame emission");

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != scrf_pkg::ST_IDLE) |-> (idx_reg < len_reg))
        else $error("emit index beyond frame length");

    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == scrf_pkg::ST_RD) |=> (st_reg == scrf_pkg::ST_LOAD))
        else $error("read not followed by load");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (load_byte && last_byte) |=> ((st_reg == scrf_pkg::ST_IDLE) && out_valid && last))
        else $error("final reply byte did not close frame");
`endif

endmodule

`default_nettype wire

[rtl/serial_command_reply_framer_top.sv]
`default_nettype none

// Serial command/reply framer.
// Input channel (in_valid/in_ready, func, rx_byte): one event per transfer:
//   received byte, 1 ms tick, send request or abort.
// Output channel (out_valid/out_ready, kind, data, last): a tick may give
//   "transmit command now" or "gave up"; a send request while a command is
//   pending gives "busy"; a frame ending in ETX gives its bytes (start byte
//   through ETX) with last on the ETX; an over-long frame gives one overflow
//   result. Events with nothing to report give no transfer.
// Latency: a single result is presented the cycle after its event transfer.
//   A frame is read back one byte at a time, each by a read and a load of
//   the frame RAM; a read and a load also precede the first byte after ETX.
// Throughput: one event per cycle while no frame is emitting and the output
//   register is free or draining; input waits until the frame is all loaded.
// Config over APB: 0x0 quiet gap, 0x4 reply timeout, 0x8 try limit; write
//   only while idle. pready is tied high.
// Reset (async, rst_n low): no command pending, frame empty, no silence wait,
//   reply timer saturated, config back to 50/1000/5. Frame RAM is not cleared.
// Receiver stall: a result waits in the output register; input is held off
//   until it drains, and frame emission pauses byte by byte.

module serial_command_reply_framer_top #(
    parameter int REPLY_BYTES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // event input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  rx_byte,
    // result output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [2:0]  kind,
    output logic      [7:0]  data,
    output logic             last
);

    localparam int PW = $clog2(REPLY_BYTES);

    scrf_pkg::cfg_t cfg;
    scrf_pkg::evt_t evt;

    logic          accept;
    logic          rdy;
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic          ram_re;
    logic [PW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [PW-1:0] emit_len;

    assign in_ready = rdy;
    assign accept   = in_valid && rdy;

    scrf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // event decode and scalar state; writes each framed byte into the RAM
    scrf_core #(
        .REPLY_BYTES (REPLY_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (func),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .evt       (evt),
        .emit_len  (emit_len)
    );

    // frame store
    scrf_ram #(
        .WIDTH (8),
        .DEPTH (REPLY_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // frame read-back sequencer and output register
    scrf_out #(
        .REPLY_BYTES (REPLY_BYTES)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .evt       (evt),
        .emit_len  (emit_len),
        .rdy       (rdy),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

endmodule

`default_nettype wire
